// ===== src/deq_pkg.sv =====
// Shared widths, operation codes and status codes for the double-ended queue.
package deq_pkg;

    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_BACK   = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_REVERSE    = 3'd4,
        MODE_REPORT     = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

endpackage

// ===== src/deq_store.sv =====
// Ring store: one write port and two registered read ports.
module deq_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== src/double_ended_queue.sv =====
// Bounded double-ended queue built around a ring store with two read ports.
//
// Usage:
//   The request channel (s_valid/s_ready) carries an operation code s_mode
//   (push back, push front, pop back, pop front, reverse, report) and a
//   signed s_value used only by pushes. Every request yields exactly one
//   result on the m_ channel: status, front and back values, empty flag and
//   the entry count after the operation.
//   Once a request is taken the block updates the pointers and writes the
//   store, then reads the store, then captures the result and raises m_valid.
//   No new request is taken until the last one is captured; the store write,
//   the registered read of the first and last slots and the result capture
//   run one after another for each request.
//   A result waits in the output register while the next request is taken;
//   if the receiver still stalls when that next result is ready, the block
//   holds it and takes no further request until the output frees up.
//   Reset (aresetn low, synchronous) empties the queue, clears the head
//   pointer and the reversed flag and drops any pending result. The store
//   itself is not cleared; only occupied slots are ever shown.
//   Full pushes return overflow, empty pops return underflow, and front and
//   back read zero while the queue is empty.
module double_ended_queue #(
    parameter int CAPACITY = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [deq_pkg::MODE_W-1:0]    s_mode,
    input  logic signed [deq_pkg::VALUE_W-1:0] s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [deq_pkg::STATUS_W-1:0]  m_status,
    output logic signed [deq_pkg::VALUE_W-1:0] m_front_value,
    output logic signed [deq_pkg::VALUE_W-1:0] m_back_value,
    output logic                          m_is_empty,
    output logic [deq_pkg::COUNT_W-1:0]   m_count
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = PTR_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_CAPT = 3'b100
    } state_t;

    // Wrap base + off into the ring; off never exceeds CAPACITY.
    function automatic logic [PTR_W-1:0] slot_add(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = {1'b0, base} + SUM_W'(off);
        if (s >= SUM_W'(CAPACITY)) begin
            s = s - SUM_W'(CAPACITY);
        end
        return s[PTR_W-1:0];
    endfunction

    state_t                 state_reg, state_next;
    logic [PTR_W-1:0]       head_reg, head_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   rev_reg, rev_next;
    deq_pkg::status_t       status_reg, status_next;

    logic                   m_valid_reg, m_valid_next;
    deq_pkg::status_t       out_status_reg;
    logic [deq_pkg::VALUE_W-1:0] out_front_reg, out_back_reg;
    logic                   out_empty_reg;
    logic [deq_pkg::COUNT_W-1:0] out_count_reg;

    logic                   we;
    logic [PTR_W-1:0]       waddr;
    logic [PTR_W-1:0]       head_dec, head_inc, tail_slot, last_slot;
    logic [CNT_W-1:0]       last_off;
    logic                   is_full, is_empty_now;
    logic                   push_first, pop_first;
    logic                   capture;
    logic [deq_pkg::VALUE_W-1:0] rd_first, rd_last;

    // Ring arithmetic around the current head.
    assign head_dec     = (head_reg == '0) ? PTR_W'(CAPACITY - 1) : head_reg - 1'b1;
    assign head_inc     = slot_add(head_reg, CNT_W'(1));
    assign tail_slot    = slot_add(head_reg, count_reg);
    assign last_off     = (count_reg == '0) ? '0 : count_reg - 1'b1;
    assign last_slot    = slot_add(head_reg, last_off);
    assign is_full      = (count_reg == CNT_W'(CAPACITY));
    assign is_empty_now = (count_reg == '0);

    // Logical front maps to the physical first slot unless reversed.
    assign push_first = (s_mode == deq_pkg::MODE_PUSH_FRONT) ^ rev_reg;
    assign pop_first  = (s_mode == deq_pkg::MODE_POP_FRONT) ^ rev_reg;

    assign s_ready = (state_reg == ST_IDLE);
    // Move the read data into the output register once it is free.
    assign capture = (state_reg == ST_CAPT) && (!m_valid_reg || m_ready);

    deq_store #(
        .DEPTH (CAPACITY),
        .WIDTH (deq_pkg::VALUE_W)
    ) u_store (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (s_value),
        .re      (state_reg == ST_READ),
        .raddr_a (head_reg),
        .raddr_b (last_slot),
        .rdata_a (rd_first),
        .rdata_b (rd_last)
    );

    // Request decode: update pointers and write the store on acceptance.
    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        rev_next    = rev_reg;
        status_next = status_reg;
        we          = 1'b0;
        waddr       = tail_slot;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next  = ST_READ;
                    status_next = deq_pkg::STATUS_DONE;
                    unique case (s_mode)
                        deq_pkg::MODE_PUSH_BACK,
                        deq_pkg::MODE_PUSH_FRONT: begin
                            if (is_full) begin
                                status_next = deq_pkg::STATUS_OVERFLOW;
                            end else begin
                                we         = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (push_first) begin
                                    head_next = head_dec;
                                    waddr     = head_dec;
                                end
                            end
                        end
                        deq_pkg::MODE_POP_BACK,
                        deq_pkg::MODE_POP_FRONT: begin
                            if (is_empty_now) begin
                                status_next = deq_pkg::STATUS_UNDERFLOW;
                            end else begin
                                count_next = count_reg - 1'b1;
                                if (pop_first) begin
                                    head_next = head_inc;
                                end
                            end
                        end
                        deq_pkg::MODE_REVERSE: begin
                            rev_next = !rev_reg;
                        end
                        default: begin
                            // report only, also for unused codes
                        end
                    endcase
                end
            end
            ST_READ: begin
                state_next = ST_CAPT;
            end
            ST_CAPT: begin
                if (capture) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            rev_reg    <= 1'b0;
            status_reg <= deq_pkg::STATUS_DONE;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            rev_reg    <= rev_next;
            status_reg <= status_next;
        end
    end

    // Output register: hold while stalled, drop once taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (capture) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            out_status_reg <= status_reg;
            out_empty_reg  <= is_empty_now;
            out_count_reg  <= deq_pkg::COUNT_W'(count_reg);
            if (is_empty_now) begin
                out_front_reg <= '0;
                out_back_reg  <= '0;
            end else begin
                out_front_reg <= rev_reg ? rd_last : rd_first;
                out_back_reg  <= rev_reg ? rd_first : rd_last;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = out_status_reg;
    assign m_front_value = out_front_reg;
    assign m_back_value  = out_back_reg;
    assign m_is_empty    = out_empty_reg;
    assign m_count       = out_count_reg;

endmodule

// ===== src/deq_chk.sv =====
// Port-level checks for the double-ended queue, bound to the top level.
module deq_chk #(
    parameter int CAPACITY = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [deq_pkg::STATUS_W-1:0]  m_status,
    input logic signed [deq_pkg::VALUE_W-1:0] m_front_value,
    input logic signed [deq_pkg::VALUE_W-1:0] m_back_value,
    input logic                          m_is_empty,
    input logic [deq_pkg::COUNT_W-1:0]   m_count
);

    // An empty result shows zero values and zero count.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_empty |->
            m_front_value == '0 && m_back_value == '0 && m_count == '0)
        else $error("empty result with nonzero fields");

    // A refused pop only happens on an empty queue.
    a_underflow_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == deq_pkg::STATUS_UNDERFLOW |-> m_is_empty)
        else $error("underflow on a nonempty queue");

    // A refused push only happens on a full queue.
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == deq_pkg::STATUS_OVERFLOW |->
            m_count == deq_pkg::COUNT_W'(CAPACITY) && !m_is_empty)
        else $error("overflow on a queue that is not full");

    // With a single entry, front and back are the same value.
    a_single_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && CAPACITY < 32 && m_count == deq_pkg::COUNT_W'(1) |->
            m_front_value == m_back_value)
        else $error("single entry with differing front and back");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
            $stable(m_front_value) && $stable(m_back_value) && $stable(m_count))
        else $error("result changed while stalled");

endmodule

bind double_ended_queue deq_chk #(.CAPACITY(CAPACITY)) u_deq_chk (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the double_ended_queue block, with its own deque predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 200000;

    // Opcodes beyond the enum; the block treats them as report-only requests.
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    // What one result shows: status and the queue as seen after the request.
    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  front;
        logic signed [VALUE_W-1:0]  back;
        logic                       empty;
        logic [COUNT_W-1:0]         count;
    } deq_view_t;

    // One line of the directed plan. A typed row carries its expected view;
    // the others are left to the predictor.
    typedef struct packed {
        logic [MODE_W-1:0]          op;
        logic signed [VALUE_W-1:0]  val;
        logic [5:0]                 reps;
        logic                       typed;
        deq_view_t                  view;
    } plan_row_t;

    localparam deq_view_t VIEW_EMPTY = '{STATUS_DONE, 32'sh0, 32'sh0, 1'b1, 5'd0};
    localparam deq_view_t VIEW_DRY   = '{STATUS_UNDERFLOW, 32'sh0, 32'sh0, 1'b1, 5'd0};

    localparam int PLAN_ROWS = 14;
    localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
        // Pops on an empty queue are refused and leave front/back at zero.
        '{MODE_POP_BACK,   32'sh0,          6'd1,  1'b1, VIEW_DRY},
        '{MODE_POP_FRONT,  32'sh0,          6'd1,  1'b1, VIEW_DRY},
        // Reverse on an empty queue only flips the direction.
        '{MODE_REVERSE,    32'sh0,          6'd1,  1'b1, VIEW_EMPTY},
        '{MODE_SPARE_6,    32'shFFFF_FFFF,  6'd1,  1'b1, VIEW_EMPTY},
        '{MODE_SPARE_7,    32'sh0,          6'd1,  1'b1, VIEW_EMPTY},
        '{MODE_REVERSE,    32'sh0,          6'd1,  1'b1, VIEW_EMPTY},
        '{MODE_PUSH_BACK,  32'sh7FFF_FFFF,  6'd1,  1'b1,
          '{STATUS_DONE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 5'd1}},
        // Reverse a single entry, then push at the new logical front.
        '{MODE_REVERSE,    32'sh0,          6'd1,  1'b1,
          '{STATUS_DONE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 5'd1}},
        '{MODE_PUSH_FRONT, 32'sh8000_0000,  6'd1,  1'b1,
          '{STATUS_DONE, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 5'd2}},
        '{MODE_REVERSE,    32'sh0,          6'd1,  1'b1,
          '{STATUS_DONE, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 5'd2}},
        '{MODE_POP_FRONT,  32'sh0,          6'd1,  1'b1,
          '{STATUS_DONE, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 5'd1}},
        '{MODE_POP_BACK,   32'sh0,          6'd1,  1'b1, VIEW_EMPTY},
        // Fill to capacity, then a push at the front must overflow.
        '{MODE_PUSH_BACK,  32'sh5A5A_5A5A,  6'd16, 1'b0, VIEW_EMPTY},
        '{MODE_PUSH_FRONT, 32'sh1234_5678,  6'd1,  1'b1,
          '{STATUS_OVERFLOW, 32'sh5A5A_5A5A, 32'sh5A5A_5A5A, 1'b0, 5'd16}}
    };

    logic                        aclk    = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [MODE_W-1:0]           s_mode  = '0;
    logic signed [VALUE_W-1:0]   s_value = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [STATUS_W-1:0]         m_status;
    logic signed [VALUE_W-1:0]   m_front_value;
    logic signed [VALUE_W-1:0]   m_back_value;
    logic                        m_is_empty;
    logic [COUNT_W-1:0]          m_count;

    // Predictor state: ring store, head slot, fill level and direction flag.
    logic signed [VALUE_W-1:0]   ring_slots [DEPTH];
    int                          ring_head  = 0;
    int                          ring_fill  = 0;
    logic                        ring_flipped = 1'b0;

    deq_view_t                   pending_views [$];
    int                          send_idle_pct  = 24;
    int                          recv_stall_pct = 49;
    int                          mismatch_count = 0;
    int                          results_seen   = 0;
    int                          cycle_count    = 0;

    double_ended_queue #(.CAPACITY(DEPTH)) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_front_value (m_front_value),
        .m_back_value  (m_back_value),
        .m_is_empty    (m_is_empty),
        .m_count       (m_count)
    );

    always #2 aclk = ~aclk;

    // Apply one request to the predictor and return the view the block must show.
    function automatic deq_view_t apply_deque_op(logic [MODE_W-1:0] op,
                                                 logic signed [VALUE_W-1:0] val);
        deq_view_t view;
        logic      at_first;
        int        tail_slot;
        view = '{STATUS_DONE, 32'sh0, 32'sh0, 1'b1, 5'd0};
        case (op)
            MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
                // The logical front is the first stored slot unless reversed.
                at_first = (op == MODE_PUSH_FRONT) != ring_flipped;
                if (ring_fill >= DEPTH) begin
                    view.status = STATUS_OVERFLOW;
                end else begin
                    if (at_first) begin
                        ring_head = (ring_head == 0) ? DEPTH - 1 : ring_head - 1;
                        ring_slots[ring_head] = val;
                    end else begin
                        ring_slots[(ring_head + ring_fill) % DEPTH] = val;
                    end
                    ring_fill++;
                end
            end
            MODE_POP_BACK, MODE_POP_FRONT: begin
                at_first = (op == MODE_POP_FRONT) != ring_flipped;
                if (ring_fill == 0) begin
                    view.status = STATUS_UNDERFLOW;
                end else begin
                    if (at_first)
                        ring_head = (ring_head + 1) % DEPTH;
                    ring_fill--;
                end
            end
            MODE_REVERSE: begin
                ring_flipped = !ring_flipped;
            end
            default: begin
            end
        endcase
        if (ring_fill != 0) begin
            tail_slot  = (ring_head + ring_fill - 1) % DEPTH;
            view.front = ring_flipped ? ring_slots[tail_slot] : ring_slots[ring_head];
            view.back  = ring_flipped ? ring_slots[ring_head] : ring_slots[tail_slot];
        end
        view.empty = (ring_fill == 0);
        view.count = COUNT_W'(ring_fill);
        return view;
    endfunction

    // Log one mismatch on a line of its own and count it.
    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("[%0t] result %0d: %s", $realtime, results_seen, what);
    endtask

    // Offer one request, hold it until taken, then record what it must produce.
    // Call only right after a rising edge; valid is touched once per edge.
    task automatic send_request(logic [MODE_W-1:0] op, logic signed [VALUE_W-1:0] val,
                                logic typed, deq_view_t typed_view);
        deq_view_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= op;
        s_value <= val;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        // Advance the predictor even when the row carries its own expectation.
        predicted = apply_deque_op(op, val);
        pending_views.push_back(typed ? typed_view : predicted);
    endtask

    // Receiver: stall at random and check every taken result against the oldest
    // pending expectation, field by field.
    always @(posedge aclk) begin
        deq_view_t want;
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (pending_views.size() == 0) begin
                report_mismatch("result arrived with no request pending");
            end else begin
                want = pending_views.pop_front();
                if (m_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_status, want.status));
                if (m_front_value !== want.front)
                    report_mismatch($sformatf("front %0d, expected %0d",
                                              m_front_value, want.front));
                if (m_back_value !== want.back)
                    report_mismatch($sformatf("back %0d, expected %0d",
                                              m_back_value, want.back));
                if (m_is_empty !== want.empty)
                    report_mismatch($sformatf("is_empty %0b, expected %0b",
                                              m_is_empty, want.empty));
                if (m_count !== want.count)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              m_count, want.count));
            end
            results_seen++;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        logic [MODE_W-1:0]         op;
        logic signed [VALUE_W-1:0] val;
        logic                      growing;
        int                        tide_left;
        int                        pick;
        growing   = 1'b1;
        tide_left = 0;

        // Hold reset low from the start, then release it once.
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the directed plan: empty-queue corner cases, extremes, full queue.
        for (int r = 0; r < PLAN_ROWS; r++) begin
            for (int k = 0; k < DIRECTED_PLAN[r].reps; k++)
                send_request(DIRECTED_PLAN[r].op, DIRECTED_PLAN[r].val,
                             DIRECTED_PLAN[r].typed, DIRECTED_PLAN[r].view);
        end

        // Random traffic in tides: each run mostly grows or mostly drains the queue,
        // picked at random per run, so both full and empty are hit repeatedly.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct  = 49;
                recv_stall_pct = 24;
            end
            if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            if (tide_left == 0) begin
                growing   = 1'($urandom_range(1));
                tide_left = $urandom_range(40, 8);
            end
            tide_left--;

            pick = $urandom_range(99);
            if (pick < 72)
                op = growing ? ($urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK)
                             : ($urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK);
            else if (pick < 88)
                op = growing ? ($urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK)
                             : ($urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK);
            else if (pick < 95)
                op = MODE_REVERSE;
            else
                op = MODE_W'($urandom_range(MODE_SPARE_7, MODE_REPORT));

            // Full-range values half the time, otherwise an extreme, minus one or zero.
            case ($urandom_range(7))
                0:       val = 32'sh8000_0000;
                1:       val = 32'sh7FFF_FFFF;
                2:       val = -32'sd1;
                3:       val = 32'sh0;
                default: val = $urandom();
            endcase
            send_request(op, val, 1'b0, VIEW_EMPTY);
        end
        s_valid <= 1'b0;

        // Drain: wait for every expected result, then keep watching for anything
        // unexpected before the verdict.
        while (pending_views.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
